FILE: rtl/core/rbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbc_pkg;

	// One recurrence term, always held below the fold modulus.
	typedef logic [15:0] term_t;

	// Byte index, kept modulo 256.
	typedef logic [7:0] index_t;

	// One result transaction as it waits in the output register.
	typedef struct packed {
		term_t checksum;
		logic  checksum_nonzero;
	} result_t;

	localparam term_t  FirstOffset = 16'd7;
	localparam index_t AlphaMul    = 8'd17;
	localparam index_t BetaMul     = 8'd31;
	localparam term_t  FoldMod     = 16'hFFFF;
	localparam term_t  PrevReset   = 16'd1;

endpackage

`default_nettype wire

FILE: rtl/core/rbc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte stream channel: one message byte and its end marker per transaction.
interface rbc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rbc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Result channel: one checksum and its nonzero flag per transaction.
interface rbc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] checksum;
	logic        checksum_nonzero;

	modport source (output valid, output checksum, output checksum_nonzero, input ready);
	modport sink (input valid, input checksum, input checksum_nonzero, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/recurrence_byte_checksum.sv
`timescale 1ns / 1ps
`default_nettype none

// Recurrence byte checksum.
// Bytes of a message arrive on byte_stream, one per transaction, with
// last_byte set on the final byte. Each byte is folded into a second-order
// recurrence modulo 65535; after the last byte one transaction on result
// carries the 16-bit checksum and a flag that is set when it is nonzero.
// Bytes without last_byte produce no result transaction.
// Throughput: one byte per cycle, except while a last byte waits in the
// input register for a full output register. A byte lands in the input
// register when it is accepted and is then folded into the term registers;
// a last byte's checksum then passes into the output register on result.
// The cycle time is set by the multiply-subtract-fold path that
// feeds the term registers back into themselves.
// Reset clears the input and output registers and puts the recurrence in
// its start state; the block then accepts bytes at once.
// While result is stalled, the output register holds its checksum. Ordinary
// bytes keep flowing; a last byte that finds the output register full waits
// in the input register, and byte_stream.ready drops until the result
// transaction completes.
module recurrence_byte_checksum (
	input  wire logic clk,
	input  wire logic arst_n,
	rbc_in_if.sink    byte_stream,
	rbc_out_if.source result
);

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              last_s1;
	rbc_pkg::term_t    prev_q;
	rbc_pkg::term_t    curr_q;
	rbc_pkg::index_t   idx_q;
	logic              started_q;
	logic              can_push;
	logic              fire_s1;
	logic              push;
	rbc_pkg::term_t    next_term;
	rbc_pkg::term_t    new_curr;
	rbc_pkg::result_t  push_data;

	// Stage 1 advances unless it holds a last byte that the output cannot take.
	assign fire_s1           = valid_s1 && (!last_s1 || can_push);
	assign byte_stream.ready = !valid_s1 || fire_s1;
	assign push              = fire_s1 && last_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready) begin
			data_s1 <= byte_stream.data_byte;
			last_s1 <= byte_stream.last_byte;
		end
	end

	// Recurrence step for the byte in stage 1.
	rbc_fold u_fold (
		.data_byte  (data_s1),
		.byte_index (idx_q),
		.curr_term  (curr_q),
		.prev_term  (prev_q),
		.next_term  (next_term)
	);

	// The first byte of a message seeds the current term directly.
	assign new_curr = started_q ? next_term : (16'(data_s1) + rbc_pkg::FirstOffset);

	assign push_data.checksum         = new_curr;
	assign push_data.checksum_nonzero = (new_curr != '0);

	// Recurrence state; a last byte returns it to the start state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= rbc_pkg::PrevReset;
			curr_q    <= '0;
			idx_q     <= '0;
			started_q <= 1'b0;
		end else if (fire_s1) begin
			if (last_s1) begin
				prev_q    <= rbc_pkg::PrevReset;
				curr_q    <= '0;
				idx_q     <= '0;
				started_q <= 1'b0;
			end else if (!started_q) begin
				prev_q    <= rbc_pkg::PrevReset;
				curr_q    <= new_curr;
				idx_q     <= 8'd1;
				started_q <= 1'b1;
			end else begin
				prev_q    <= curr_q;
				curr_q    <= new_curr;
				idx_q     <= idx_q + 8'd1;
				started_q <= 1'b1;
			end
		end
	end

	// Result register.
	rbc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.can_push  (can_push),
		.result    (result)
	);

`ifndef SYNTHESIS
	// A completed message leaves the recurrence in its start state.
	assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (!started_q && idx_q == '0 && prev_q == rbc_pkg::PrevReset && curr_q == '0))
		else $error("recurrence not returned to start state after last byte");

	// Before the first byte of a message the terms hold their start values.
	assert property (@(posedge clk) disable iff (!arst_n)
		!started_q |-> (prev_q == rbc_pkg::PrevReset && curr_q == '0 && idx_q == '0))
		else $error("start state corrupted");

	// The fold never yields the modulus itself, and the flag matches the value.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.checksum != rbc_pkg::FoldMod &&
			result.checksum_nonzero == (result.checksum != '0)))
		else $error("result checksum out of range or flag mismatch");

	// Input backpressure only comes from a last byte waiting on a full output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!byte_stream.ready |-> (valid_s1 && last_s1 && result.valid && !result.ready))
		else $error("input stalled without a pending result");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/rbc_fold.sv
`timescale 1ns / 1ps
`default_nettype none

// One step of the second-order recurrence, folded modulo 65535.
module rbc_fold (
	input  wire logic [7:0]    data_byte,
	input  wire rbc_pkg::index_t byte_index,
	input  wire rbc_pkg::term_t  curr_term,
	input  wire rbc_pkg::term_t  prev_term,
	output rbc_pkg::term_t       next_term
);

	logic [12:0]    alpha_full;
	logic [12:0]    beta_full;
	logic [8:0]     coef_a;
	logic [24:0]    prod_a;
	logic [24:0]    prod_b;
	logic           a_ge_b;
	logic [24:0]    diff;
	rbc_pkg::term_t folded;

	// Reduce a 25-bit value modulo 65535: 2^16 is congruent to 1, so the
	// high and low halves are added and one subtraction finishes the job.
	function automatic rbc_pkg::term_t fold_mod(input logic [24:0] x);
		logic [16:0] s;
		s = 17'(x[24:16]) + 17'(x[15:0]);
		if (s >= 17'(rbc_pkg::FoldMod)) begin
			s = s - 17'(rbc_pkg::FoldMod);
		end
		return s[15:0];
	endfunction

	// Index-dependent coefficients, each taken modulo 256.
	assign alpha_full = 13'(byte_index) * 13'(rbc_pkg::AlphaMul);
	assign beta_full  = 13'(byte_index) * 13'(rbc_pkg::BetaMul);
	assign coef_a     = 9'(data_byte) + 9'(alpha_full[7:0]);

	// Both products in parallel.
	assign prod_a = 25'(coef_a) * 25'(curr_term);
	assign prod_b = 25'(beta_full[7:0]) * 25'(prev_term);

	// A negative difference wraps as (diff + 1) mod 65535, which is
	// 65535 - ((b - a - 1) mod 65535), or zero when that remainder is zero.
	assign a_ge_b = (prod_a >= prod_b);
	assign diff   = a_ge_b ? (prod_a - prod_b) : (prod_b - prod_a - 25'd1);
	assign folded = fold_mod(diff);

	always_comb begin
		if (a_ge_b) begin
			next_term = folded;
		end else if (folded == '0) begin
			next_term = '0;
		end else begin
			next_term = rbc_pkg::FoldMod - folded;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/rbc_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

// Output register that holds one result transaction until the sink takes it.
module rbc_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire rbc_pkg::result_t  push_data,
	output logic                   can_push,
	rbc_out_if.source              result
);

	logic              valid_q;
	rbc_pkg::result_t  data_q;

	// A new result may enter when the register is empty or drains this cycle.
	assign can_push = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

	assign result.valid            = valid_q;
	assign result.checksum         = data_q.checksum;
	assign result.checksum_nonzero = data_q.checksum_nonzero;

endmodule

`default_nettype wire
